>>> src/frq_pkg.sv
`default_nettype none

package frq_pkg;

  // Fixed field widths of the ports
  localparam int IN_BITS  = 64;
  localparam int OUT_BITS = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  // Signed width for bit positions and shift amounts
  localparam int SHW = 9;

  // Parameter defaults
  localparam int IN_W_DEF      = 64;
  localparam int IN_INT_W_DEF  = 24;
  localparam int OUT_W_MAX_DEF = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_INT_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_SIGNED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_BITS      = 3'd5;

  typedef enum logic [2:0] {
    Q_RND         = 3'd0,
    Q_RND_ZERO    = 3'd1,
    Q_RND_MIN_INF = 3'd2,
    Q_RND_INF     = 3'd3,
    Q_RND_CONV    = 3'd4,
    Q_TRN         = 3'd5,
    Q_TRN_ZERO    = 3'd6
  } quant_e;

  typedef enum logic [2:0] {
    O_SAT      = 3'd0,
    O_SAT_ZERO = 3'd1,
    O_SAT_SYM  = 3'd2,
    O_WRAP     = 3'd3,
    O_WRAP_SM  = 3'd4
  } ovf_e;

  typedef struct packed {
    logic [5:0] out_width;
    logic [4:0] out_int_width;
    logic       is_signed;
    quant_e     quant_mode;
    ovf_e       overflow_mode;
    logic [5:0] sat_bits;
  } frq_cfg_t;

  // Aligned value and the bit summaries the second stage needs
  typedef struct packed {
    logic [OUT_BITS-1:0] ret;
    logic                qb;    // first dropped bit
    logic                rem;   // any dropped bit below it
    logic                vneg;
    logic                vnz;
    logic                ld;    // bit just above the result's integer part
    logic                p1_lt; // bit one above the result top lies inside the input
    logic                r1o;   // all ones from one above the result top
    logic                r1z;   // all zeros from one above the result top
    logic                r2o;   // all ones from two above the result top
  } frq_mid_t;

  // Clamp the configured width into 1..max
  function automatic logic [5:0] eff_width(logic [5:0] raw, logic [5:0] max_w);
    logic [5:0] w;
    if (raw == 6'd0) begin
      w = 6'd1;
    end else if (raw > max_w) begin
      w = max_w;
    end else begin
      w = raw;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/frq_align.sv
`default_nettype none

module frq_align import frq_pkg::*; #(
  parameter int IN_W      = IN_W_DEF,
  parameter int IN_INT_W  = IN_INT_W_DEF,
  parameter int OUT_W_MAX = OUT_W_MAX_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [IN_W-1:0] value_i,
  input  wire frq_cfg_t        cfg_i,
  output logic                 valid_o,
  output frq_mid_t             mid_o
);

  localparam logic signed [SHW-1:0] FE_S   = SHW'(IN_W - IN_INT_W);
  localparam logic signed [SHW-1:0] LIM64  = SHW'(IN_BITS);
  localparam logic signed [SHW-1:0] LIM_IN = SHW'(IN_W);
  localparam logic signed [SHW-1:0] ONE_S  = SHW'(1);

  function automatic logic ones_from(logic [IN_BITS-1:0] x, logic [5:0] p);
    logic [IN_BITS-1:0] hm;
    hm = {IN_BITS{1'b1}} << p;
    return (x & hm) == hm;
  endfunction

  function automatic logic zeros_from(logic [IN_BITS-1:0] x, logic [5:0] p);
    logic [IN_BITS-1:0] hm;
    hm = {IN_BITS{1'b1}} << p;
    return (x & hm) == '0;
  endfunction

  logic signed [IN_BITS-1:0] v;
  logic [5:0]                w;
  logic [OUT_BITS-1:0]       wm;
  logic signed [SHW-1:0]     sh, sm1, fei, p1, p2;
  logic [SHW-1:0]            mag;
  logic [IN_BITS-1:0]        full;
  logic [IN_BITS-1:0]        lm;
  frq_mid_t                  mid_d;
  logic                      valid_q;
  frq_mid_t                  mid_q;

  always_comb begin
    v   = IN_BITS'($signed(value_i));
    w   = eff_width(cfg_i.out_width, 6'(OUT_W_MAX));
    wm  = {OUT_BITS{1'b1}} >> (6'(OUT_BITS) - w);
    sh  = FE_S - $signed({3'b000, w}) + $signed({4'b0000, cfg_i.out_int_width});
    sm1 = sh - ONE_S;
    fei = FE_S + $signed({4'b0000, cfg_i.out_int_width});
    p1  = sh + $signed({3'b000, w});
    p2  = p1 + ONE_S;

    // Negative shift moves left, positive shift moves right with sign fill
    mag  = sh[SHW-1] ? SHW'(-sh) : SHW'(sh);
    full = sh[SHW-1] ? (v << mag) : (v >>> mag);

    mid_d      = '0;
    mid_d.ret  = full[OUT_BITS-1:0] & wm;
    mid_d.vneg = v[IN_BITS-1];
    mid_d.vnz  = (v != '0);

    if (sm1[SHW-1]) begin
      mid_d.qb = 1'b0;
    end else if (sm1 >= LIM64) begin
      mid_d.qb = v[IN_BITS-1];
    end else begin
      mid_d.qb = v[sm1[5:0]];
    end

    lm = ~({IN_BITS{1'b1}} << sm1[5:0]);
    if (sm1[SHW-1] || sm1 == '0) begin
      mid_d.rem = 1'b0;
    end else if (sm1 >= LIM64) begin
      mid_d.rem = (v != '0);
    end else begin
      mid_d.rem = ((v & lm) != '0);
    end

    if (fei[SHW-1]) begin
      mid_d.ld = 1'b0;
    end else if (fei >= LIM64) begin
      mid_d.ld = v[IN_BITS-1];
    end else begin
      mid_d.ld = v[fei[5:0]];
    end

    mid_d.p1_lt = (p1 < LIM_IN);
    if (mid_d.p1_lt && !p1[SHW-1]) begin
      mid_d.r1o = ones_from(v, p1[5:0]);
      mid_d.r1z = zeros_from(v, p1[5:0]);
    end

    if (p2[SHW-1]) begin
      mid_d.r2o = 1'b0;
    end else if (p2 >= LIM_IN) begin
      mid_d.r2o = 1'b1;
    end else begin
      mid_d.r2o = ones_from(v, p2[5:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign mid_o   = mid_q;

endmodule

`default_nettype wire

>>> src/frq_resolve.sv
`default_nettype none

module frq_resolve import frq_pkg::*; #(
  parameter int IN_INT_W  = IN_INT_W_DEF,
  parameter int OUT_W_MAX = OUT_W_MAX_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire frq_mid_t      mid_i,
  input  wire frq_cfg_t      cfg_i,
  output logic               done_o,
  output logic [OUT_BITS-1:0] result_o,
  output logic               ovf_o,
  output logic               unf_o
);

  function automatic logic [OUT_BITS-1:0] fix_range(
    logic [OUT_BITS-1:0] r_in, logic [5:0] w, logic [OUT_BITS-1:0] wm,
    logic [OUT_BITS-1:0] top, logic [5:0] nb, ovf_e o, logic sg,
    logic ov, logic un, logic ld, logic neg
  );
    logic [OUT_BITS-1:0] r;
    logic [OUT_BITS-1:0] keep;
    logic [4:0]          li;
    logic                ro;
    r    = r_in;
    keep = (nb >= w) ? '0 : (wm >> nb);
    li   = (nb >= w) ? 5'd0 : 5'(w - nb);
    ro   = ((r & top) != '0);
    case (o)
      O_WRAP: begin
        if (nb != 6'd0) begin
          if (sg) begin
            if (nb > 6'd1) begin
              r = neg ? (r & keep) : (r | (wm & ~keep));
            end
            r = neg ? (r | top) : (r & ~top);
          end else begin
            r = neg ? (r & keep) : (r | (wm & ~keep));
          end
        end
      end
      O_SAT_ZERO: begin
        r = '0;
      end
      O_WRAP_SM: begin
        if (nb == 6'd0) begin
          if (ld != ro) begin
            r = ~r & wm;
            r = ld ? (r | top) : (r & ~top);
          end
        end else if (nb == 6'd1) begin
          if (neg != ro) begin
            r = ~r & wm;
          end
        end else begin
          if (r[li] == neg) begin
            r = ~r & wm;
          end
          r = neg ? (r & keep) : (r | (wm & ~keep));
          r = neg ? (r | top) : (r & ~top);
        end
      end
      default: begin
        if (sg) begin
          if (ov) begin
            r = wm & ~top;
          end else if (un) begin
            r = top | ((o == O_SAT_SYM) ? OUT_BITS'(1) : '0);
          end
        end else begin
          if (ov) begin
            r = wm;
          end else if (un) begin
            r = '0;
          end
        end
      end
    endcase
    return r & wm;
  endfunction

  logic [5:0]          w;
  logic [OUT_BITS-1:0] wm, top, ret;
  quant_e              q;
  ovf_e                o;
  logic                qi, qb, c0, carry, neg, chk, iw_ok;
  logic                dz, dn, ntrg, ov, un;
  logic [OUT_BITS-1:0] result_d;
  logic                done_q, ovf_q, unf_q;
  logic [OUT_BITS-1:0] result_q;

  always_comb begin
    w   = eff_width(cfg_i.out_width, 6'(OUT_W_MAX));
    wm  = {OUT_BITS{1'b1}} >> (6'(OUT_BITS) - w);
    top = OUT_BITS'(1) << (w - 6'd1);

    case (cfg_i.quant_mode)
      Q_RND, Q_RND_ZERO, Q_RND_MIN_INF, Q_RND_INF, Q_RND_CONV, Q_TRN_ZERO: begin
        q = cfg_i.quant_mode;
      end
      default: begin
        q = Q_TRN;
      end
    endcase
    case (cfg_i.overflow_mode)
      O_SAT_ZERO, O_SAT_SYM, O_WRAP, O_WRAP_SM: begin
        o = cfg_i.overflow_mode;
      end
      default: begin
        o = O_SAT;
      end
    endcase

    ret   = mid_i.ret;
    neg   = mid_i.vneg;
    carry = 1'b0;
    ov    = 1'b0;
    un    = 1'b0;
    qb    = mid_i.qb;
    c0    = ((ret & top) != '0);
    dz    = 1'b1;
    dn    = 1'b1;
    ntrg  = 1'b0;
    qi    = (q != Q_TRN) || (o == O_SAT_SYM);
    iw_ok = ({1'b0, cfg_i.out_int_width} < 6'(IN_INT_W)) ||
            (qi && ({1'b0, cfg_i.out_int_width} == 6'(IN_INT_W)));
    chk   = ((o != O_WRAP) || (cfg_i.sat_bits != 6'd0)) && (!cfg_i.is_signed || iw_ok);

    if (mid_i.vnz) begin
      if (q != Q_TRN) begin
        case (q)
          Q_RND_ZERO:    qb = qb && (neg || mid_i.rem);
          Q_RND_MIN_INF: qb = qb && mid_i.rem;
          Q_RND_INF:     qb = qb && (!neg || mid_i.rem);
          Q_RND_CONV:    qb = qb && (ret[0] || mid_i.rem);
          Q_TRN_ZERO:    qb = neg && (qb || mid_i.rem);
          default:       qb = qb;
        endcase
        if (qb) begin
          ret = (ret + OUT_BITS'(1)) & wm;
        end
        carry = c0 && ((ret & top) == '0);
      end

      if (chk) begin
        if (mid_i.p1_lt) begin
          dz  = carry ? mid_i.r1o : mid_i.r1z;
          dn  = carry ? (mid_i.r2o && !mid_i.ld) : mid_i.r1o;
          neg = neg && !(carry && mid_i.r1o);
        end else begin
          neg = neg && ((ret & top) != '0);
        end
        ntrg = ((ret & top) != '0) && cfg_i.is_signed;
        ov   = (ntrg || !dz) && !mid_i.vneg;
        un   = (!ntrg || !dn) && neg;
        if ((o == O_SAT_SYM) && cfg_i.is_signed) begin
          un = un || (neg && ((w > 6'd1) ? (ret == top) : 1'b1));
        end
        if (ov || un) begin
          ret = fix_range(ret, w, wm, top, cfg_i.sat_bits, o, cfg_i.is_signed,
                          ov, un, mid_i.ld, neg);
        end
      end
    end
    result_d = ret;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q <= result_d;
      ovf_q    <= ov;
      unf_q    <= un;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;
  assign ovf_o    = ovf_q;
  assign unf_o    = unf_q;

endmodule

`default_nettype wire

>>> src/fixed_point_requantize.sv
// Fixed-point requantizer. Each word on in_value_i is taken at a clock edge with start high
// and busy low; busy is always low, so a new word can be issued every cycle. The result
// comes back on result_value_o, overflow_seen_o and underflow_seen_o after the input
// register, the alignment register (shift, round and sticky bits, range summaries) and the
// result register (rounding increment, overflow handling), marked by a one-cycle done_o
// pulse; the receiver cannot hold it off, so capture it on that cycle.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i and
// must only change while no word is in flight.
`default_nettype none

module fixed_point_requantize import frq_pkg::*; #(
  parameter int IN_W      = IN_W_DEF,
  parameter int IN_INT_W  = IN_INT_W_DEF,
  parameter int OUT_W_MAX = OUT_W_MAX_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [IN_BITS-1:0]    in_value_i,
  output logic                       done_o,
  output logic [OUT_BITS-1:0]        result_value_o,
  output logic                       overflow_seen_o,
  output logic                       underflow_seen_o
);

  frq_cfg_t        cfg_q;
  logic            in_valid_q;
  logic [IN_W-1:0] in_value_q;
  logic            mid_valid;
  frq_mid_t        mid;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_width     <= 6'd16;
      cfg_q.out_int_width <= 5'd8;
      cfg_q.is_signed     <= 1'b1;
      cfg_q.quant_mode    <= Q_TRN;
      cfg_q.overflow_mode <= O_WRAP;
      cfg_q.sat_bits      <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OUT_WIDTH:     cfg_q.out_width     <= cfg_data_i[5:0];
        CFG_OUT_INT_WIDTH: cfg_q.out_int_width <= cfg_data_i[4:0];
        CFG_IS_SIGNED:     cfg_q.is_signed     <= cfg_data_i[0];
        CFG_QUANT_MODE:    cfg_q.quant_mode    <= quant_e'(cfg_data_i[2:0]);
        CFG_OVERFLOW_MODE: cfg_q.overflow_mode <= ovf_e'(cfg_data_i[2:0]);
        CFG_SAT_BITS:      cfg_q.sat_bits      <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  // Only the low IN_W bits carry the value
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_value_q <= in_value_i[IN_W-1:0];
    end
  end

  frq_align #(
    .IN_W      (IN_W),
    .IN_INT_W  (IN_INT_W),
    .OUT_W_MAX (OUT_W_MAX)
  ) u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .value_i (in_value_q),
    .cfg_i   (cfg_q),
    .valid_o (mid_valid),
    .mid_o   (mid)
  );

  frq_resolve #(
    .IN_INT_W  (IN_INT_W),
    .OUT_W_MAX (OUT_W_MAX)
  ) u_resolve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mid_valid),
    .mid_i    (mid),
    .cfg_i    (cfg_q),
    .done_o   (done_o),
    .result_o (result_value_o),
    .ovf_o    (overflow_seen_o),
    .unf_o    (underflow_seen_o)
  );

endmodule

`default_nettype wire

>>> src/frq_checker.sv
`default_nettype none

module frq_checker import frq_pkg::*; #(
  parameter int IN_W = IN_W_DEF
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [IN_BITS-1:0]  in_value_i,
  input wire logic                done_o,
  input wire logic [OUT_BITS-1:0] result_value_o,
  input wire logic                overflow_seen_o,
  input wire logic                underflow_seen_o
);

  // Every accepted word returns a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("accepted word produced no result after three cycles");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 3))
    else $error("result strobe without a matching accepted word");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(overflow_seen_o && underflow_seen_o))
    else $error("overflow and underflow reported together");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_value_i[IN_W-1:0] == '0) |->
      ##3 (result_value_o == '0 && !overflow_seen_o && !underflow_seen_o))
    else $error("zero input did not give a clean zero result");

endmodule

bind fixed_point_requantize frq_checker #(.IN_W(IN_W)) u_frq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .in_value_i       (in_value_i),
  .done_o           (done_o),
  .result_value_o   (result_value_o),
  .overflow_seen_o  (overflow_seen_o),
  .underflow_seen_o (underflow_seen_o)
);

`default_nettype wire
